[sv/sps_pkg.sv]
package sps_pkg;

    localparam int FRAME_BYTES_DEF = 9;
    localparam int PUMP_COUNT_DEF  = 4;
    localparam int LONG_FRAME      = 9;
    localparam int OUT_PUMPS       = 4;
    localparam int PUMP_IDX_W      = 3;
    localparam int RUN_W           = 17;
    localparam int TICK_W          = 18;
    localparam int PRIME_W         = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [RUN_W-1:0]   DEFAULT_RUN_RST = 17'd99999;
    localparam logic [PRIME_W-1:0] PRIME_OFF_RST   = 8'd10;
    localparam logic [PRIME_W-1:0] PRIME_ON_RST    = 8'd20;
    localparam logic [TICK_W-1:0]  TICK_MAX        = '1;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RUN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_OFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_ON    = 2'd2;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_Y      = 8'h79;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_LAMP_ON,
        OP_LAMP_OFF
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [PUMP_IDX_W-1:0] pump;
        logic [RUN_W-1:0]      delay;
        logic [RUN_W-1:0]      run;
        logic                  step_req;
        logic                  close_req;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            return 4'(c - CH_0);
        end
        return 4'd0;
    endfunction

    function automatic logic [RUN_W-1:0] three_digits(input logic [7:0] c0,
                                                      input logic [7:0] c1,
                                                      input logic [7:0] c2);
        return RUN_W'(digit_value(c0)) * RUN_W'(10000)
             + RUN_W'(digit_value(c1)) * RUN_W'(1000)
             + RUN_W'(digit_value(c2)) * RUN_W'(100);
    endfunction

endpackage

[sv/sps_if.sv]
interface sps_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output mode, output rx_byte, output frame_end,
                    input ready);
    modport sink (input valid, input mode, input rx_byte, input frame_end,
                  output ready);
endinterface

interface sps_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pump_drive;
    logic [3:0] pumps_running;
    logic       lamp_on;
    logic       step_request;
    logic       close_door_request;

    modport source (output valid, output pump_drive, output pumps_running,
                    output lamp_on, output step_request, output close_door_request,
                    input ready);
    modport sink (input valid, input pump_drive, input pumps_running,
                  input lamp_on, input step_request, input close_door_request,
                  output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/sps_front.sv]
module sps_front import sps_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int PUMP_COUNT  = PUMP_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sps_in_if.sink           i_in,
    input  t_q_status        i_q_status,
    input  logic [RUN_W-1:0] i_default_run,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int CNT_W = $clog2(FRAME_BYTES + 2);
    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [7:0]       r_store [FRAME_BYTES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       view [LONG_FRAME];
    logic             store_en;

    function automatic logic pump_ok(input logic [7:0] c);
        return (c >= CH_1) && ({1'b0, c} < 9'(int'(CH_1) + PUMP_COUNT));
    endfunction

    assign i_in.ready = i_rst_n && !i_q_status.full;
    assign o_push     = i_in.valid && i_in.ready;
    assign store_en   = o_push && (i_in.mode == MODE_BYTE)
                      && (r_count < CNT_W'(FRAME_BYTES));

    // current byte merged in so that the closing byte is decoded too
    always_comb begin
        for (int i = 0; i < LONG_FRAME; i++) begin
            view[i] = (r_count == CNT_W'(i)) ? i_in.rx_byte : r_store[i];
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        n_count    = r_count;
        cnt_inc    = (r_count < CNT_W'(FRAME_BYTES)) ? r_count + 1'b1
                                                     : CNT_W'(FRAME_BYTES + 1);
        if (i_in.mode == MODE_TICK) begin
            o_cmd.op = OP_TICK;
        end else begin
            n_count = cnt_inc;
            if (i_in.frame_end) begin
                n_count = '0;
                if (cnt_inc >= CNT_W'(2) && cnt_inc <= CNT_W'(3)) begin
                    o_cmd.step_req  = (view[0] == CH_HASH && view[1] == CH_DOLLAR)
                                   || (view[0] == CH_S && view[1] == CH_T);
                    o_cmd.close_req = (view[0] == CH_Y && view[1] == CH_X);
                    o_cmd.pump      = PUMP_IDX_W'(view[1] - CH_1);
                    o_cmd.run       = i_default_run;
                    if (view[0] == CH_P && pump_ok(view[1])) begin
                        o_cmd.op = OP_START;
                    end else if (view[0] == CH_S && pump_ok(view[1])) begin
                        o_cmd.op = OP_STOP;
                    end else if (view[0] == CH_U && view[1] == CH_V) begin
                        o_cmd.op = OP_LAMP_ON;
                    end else if (view[0] == CH_V && view[1] == CH_U) begin
                        o_cmd.op = OP_LAMP_OFF;
                    end
                end else if (cnt_inc == CNT_W'(LONG_FRAME)) begin
                    if (view[0] == CH_HASH && view[1] == CH_P && pump_ok(view[2])) begin
                        o_cmd.op    = OP_START;
                        o_cmd.pump  = PUMP_IDX_W'(view[2] - CH_1);
                        o_cmd.delay = three_digits(view[3], view[4], view[5]);
                        o_cmd.run   = three_digits(view[6], view[7], view[8]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_store[r_count[IDX_W-1:0]] <= i_in.rx_byte;
        end
    end

endmodule

[sv/sps_cmd_queue.sv]
module sps_cmd_queue import sps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_cmd          = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/sps_back.sv]
module sps_back import sps_pkg::*; #(
    parameter int PUMP_COUNT = PUMP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    input  logic [RUN_W-1:0]   i_default_run,
    input  logic [PRIME_W-1:0] i_prime_off,
    input  logic [PRIME_W-1:0] i_prime_on,
    output logic               o_pop,
    sps_out_if.source          o_out
);

    logic              r_active [PUMP_COUNT];
    logic              n_active [PUMP_COUNT];
    logic              r_level  [PUMP_COUNT];
    logic              n_level  [PUMP_COUNT];
    logic [RUN_W-1:0]  r_delay  [PUMP_COUNT];
    logic [RUN_W-1:0]  n_delay  [PUMP_COUNT];
    logic [RUN_W-1:0]  r_run    [PUMP_COUNT];
    logic [RUN_W-1:0]  n_run    [PUMP_COUNT];
    logic [TICK_W-1:0] r_ticks  [PUMP_COUNT];
    logic [TICK_W-1:0] n_ticks  [PUMP_COUNT];
    logic              r_lamp;
    logic              n_lamp;

    logic              r_valid;
    logic [3:0]        r_drive;
    logic [3:0]        r_running;
    logic              r_lamp_out;
    logic              r_step;
    logic              r_close;
    logic [3:0]        drive_next;
    logic [3:0]        running_next;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    always_comb begin
        logic [TICK_W-1:0] t_next;
        logic [TICK_W-1:0] d_ext;
        t_next = '0;
        d_ext  = '0;
        n_lamp = r_lamp;
        for (int n = 0; n < PUMP_COUNT; n++) begin
            n_active[n] = r_active[n];
            n_level[n]  = r_level[n];
            n_delay[n]  = r_delay[n];
            n_run[n]    = r_run[n];
            n_ticks[n]  = r_ticks[n];
        end
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    for (int n = 0; n < PUMP_COUNT; n++) begin
                        if (r_active[n]) begin
                            t_next = (r_ticks[n] == TICK_MAX) ? r_ticks[n]
                                                              : r_ticks[n] + 1'b1;
                            d_ext  = TICK_W'(r_delay[n]);
                            n_ticks[n] = t_next;
                            if (t_next == d_ext + TICK_W'(1)) begin
                                n_level[n] = 1'b1;
                            end else if (t_next == d_ext + TICK_W'(i_prime_off)) begin
                                n_level[n] = 1'b0;
                            end else if (t_next == d_ext + TICK_W'(i_prime_on)) begin
                                n_level[n] = 1'b1;
                            end else if (t_next >= d_ext + TICK_W'(r_run[n])) begin
                                n_level[n]  = 1'b0;
                                n_ticks[n]  = '0;
                                n_active[n] = 1'b0;
                                n_run[n]    = i_default_run;
                            end
                        end
                    end
                end
                OP_START: begin
                    for (int n = 0; n < PUMP_COUNT; n++) begin
                        if (i_cmd.pump == PUMP_IDX_W'(n)) begin
                            n_active[n] = 1'b1;
                            n_delay[n]  = i_cmd.delay;
                            n_run[n]    = i_cmd.run;
                        end
                    end
                end
                OP_STOP: begin
                    for (int n = 0; n < PUMP_COUNT; n++) begin
                        if (i_cmd.pump == PUMP_IDX_W'(n)) begin
                            n_active[n] = 1'b0;
                            n_level[n]  = 1'b0;
                            n_ticks[n]  = '0;
                            n_delay[n]  = '0;
                            n_run[n]    = i_default_run;
                        end
                    end
                end
                OP_LAMP_ON:  n_lamp = 1'b1;
                OP_LAMP_OFF: n_lamp = 1'b0;
                default: ;
            endcase
        end
    end

    for (genvar b = 0; b < OUT_PUMPS; b++) begin : g_out_bits
        if (b < PUMP_COUNT) begin : g_used
            assign drive_next[b]   = n_level[b];
            assign running_next[b] = n_active[b];
        end else begin : g_unused
            assign drive_next[b]   = 1'b0;
            assign running_next[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp <= 1'b0;
            for (int n = 0; n < PUMP_COUNT; n++) begin
                r_active[n] <= 1'b0;
                r_level[n]  <= 1'b0;
                r_delay[n]  <= '0;
                r_run[n]    <= DEFAULT_RUN_RST;
                r_ticks[n]  <= '0;
            end
        end else begin
            r_lamp <= n_lamp;
            for (int n = 0; n < PUMP_COUNT; n++) begin
                r_active[n] <= n_active[n];
                r_level[n]  <= n_level[n];
                r_delay[n]  <= n_delay[n];
                r_run[n]    <= n_run[n];
                r_ticks[n]  <= n_ticks[n];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_drive    <= drive_next;
            r_running  <= running_next;
            r_lamp_out <= n_lamp;
            r_step     <= i_cmd.step_req;
            r_close    <= i_cmd.close_req;
        end
    end

    assign o_out.valid              = r_valid;
    assign o_out.pump_drive         = r_drive;
    assign o_out.pumps_running      = r_running;
    assign o_out.lamp_on            = r_lamp_out;
    assign o_out.step_request       = r_step;
    assign o_out.close_door_request = r_close;

endmodule

[sv/serial_commanded_pump_sequencer.sv]
// Serial commanded pump sequencer. Each beat on the input channel is either a received
// serial byte (mode 0, with a frame-end mark) or one 10 ms tick (mode 1), and each gives
// exactly one result beat carrying the four pump drive levels, the running mask, the lamp
// state and the step and close-door request pulses. One beat is accepted every clock cycle
// while the output side keeps taking results. The front collects and decodes frames in the
// cycle of acceptance, a two-entry command queue follows, and the back updates the pump
// channels and writes the result into the output register. The input stalls only in
// reset and when that queue is full. Configuration writes are taken whenever out of reset
// and belong to idle periods; reset needs no clearing pass.
module serial_commanded_pump_sequencer import sps_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int PUMP_COUNT  = PUMP_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_in_if.sink    i_in,
    sps_out_if.source o_out,
    sps_cfg_if.sink   i_cfg
);

    logic [RUN_W-1:0]   r_default_run;
    logic [PRIME_W-1:0] r_prime_off;
    logic [PRIME_W-1:0] r_prime_on;

    t_q_status w_q_status;
    t_cmd      w_push_cmd;
    t_cmd      w_pop_cmd;
    logic      w_push;
    logic      w_pop;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_run <= DEFAULT_RUN_RST;
            r_prime_off   <= PRIME_OFF_RST;
            r_prime_on    <= PRIME_ON_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_DEFAULT_RUN: r_default_run <= i_cfg.data[RUN_W-1:0];
                REG_PRIME_OFF:   r_prime_off   <= i_cfg.data[PRIME_W-1:0];
                REG_PRIME_ON:    r_prime_on    <= i_cfg.data[PRIME_W-1:0];
                default: ;
            endcase
        end
    end

    sps_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .PUMP_COUNT  (PUMP_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_q_status    (w_q_status),
        .i_default_run (r_default_run),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    sps_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_pop_cmd),
        .o_status (w_q_status)
    );

    sps_back #(
        .PUMP_COUNT (PUMP_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_status.valid),
        .i_cmd         (w_pop_cmd),
        .i_default_run (r_default_run),
        .i_prime_off   (r_prime_off),
        .i_prime_on    (r_prime_on),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !w_q_status.full)
        else $error("input beat taken while command queue full");

    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_pop))
        else $error("result shown without a command taken from the queue");

    a_drive_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.pump_drive & ~o_out.pumps_running) == 4'd0))
        else $error("pump driven while its sequence is inactive");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.step_request && o_out.close_door_request))
        else $error("step and close-door requests in one beat");

endmodule
